// ===== design/hsd_pkg.sv =====
// hsd_pkg: shared types and constants for the secded block decoder
`default_nettype none

package hsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MIN_LOG2 = 3;

  localparam logic [STATUS_W-1:0] STATUS_CLEAN     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd2;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_EXTRACT,
    ST_FINISH
  } state_e;

  // control from the sequencer to the bit packer
  typedef struct packed {
    logic clear;
    logic step;
    logic first;
    logic pow2;
  } pack_ctrl_t;

  // packer status back to the sequencer
  typedef struct packed {
    logic              full;
    logic [BYTE_W-1:0] data;
  } pack_stat_t;

endpackage

`default_nettype wire

// ===== design/hsd_in_if.sv =====
// hsd_in_if: coded byte channel
`default_nettype none

interface hsd_in_if;
  import hsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] coded_byte;

  modport source (output valid, output coded_byte, input ready);
  modport sink   (input valid, input coded_byte, output ready);
endinterface

`default_nettype wire

// ===== design/hsd_out_if.sv =====
// hsd_out_if: decoded result channel
`default_nettype none

interface hsd_out_if;
  import hsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   data_byte;
  logic                byte_valid;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output data_byte, output byte_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== design/hsd_packer.sv =====
// hsd_packer: picks the data bits of one block byte and packs them into output bytes
`default_nettype none

module hsd_packer
  import hsd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pack_ctrl_t        ctrl_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output pack_stat_t             stat_o
);

  logic [BYTE_W-1:0]   partial_q, partial_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [BYTE_W-1:0]   digit;
  logic [3:0]          nbits;
  logic [2*BYTE_W-1:0] merged;
  logic [3:0]          sum;

  // byte 0 holds data at 3,5,6,7; a power-of-two byte loses its bit 0
  always_comb begin
    priority if (ctrl_i.first) begin
      digit = {4'd0, byte_i[7], byte_i[6], byte_i[5], byte_i[3]};
      nbits = 4'd4;
    end else if (ctrl_i.pow2) begin
      digit = {1'b0, byte_i[7:1]};
      nbits = 4'd7;
    end else begin
      digit = byte_i;
      nbits = 4'd8;
    end
  end

  assign merged = {{BYTE_W{1'b0}}, partial_q} | ({{BYTE_W{1'b0}}, digit} << cnt_q);
  assign sum    = {1'b0, cnt_q} + nbits;

  assign stat_o.full = sum[3];
  assign stat_o.data = merged[BYTE_W-1:0];

  always_comb begin
    partial_d = partial_q;
    cnt_d     = cnt_q;
    if (ctrl_i.clear) begin
      partial_d = '0;
      cnt_d     = '0;
    end else if (ctrl_i.step) begin
      if (sum[3]) begin
        partial_d = merged[2*BYTE_W-1:BYTE_W];
      end else begin
        partial_d = merged[BYTE_W-1:0];
      end
      cnt_d = sum[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      cnt_q     <= '0;
    end else begin
      partial_q <= partial_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/hamming_secded_block_decoder_top.sv =====
// hamming_secded_block_decoder_top: extended hamming secded block decoder
//
//   channel   dir  handshake      payload
//   coded_i   in   valid/ready    coded_byte[7:0]
//   result_o  out  valid/ready    data_byte[7:0] byte_valid status[1:0] last
//   cfg       in   cfg_we_i       cfg_wdata_i[3:0] (block_log2)
//
// a coded byte is taken only in the collect state; syndrome and parity build up per byte.
// at a block end of B = 2^(block_log2-3) bytes the block store is read back one
// byte per cycle (one port, registered read), then the finish state sends the
// last result; no coded byte is taken before the finish state is done.
// a dropped block skips the readback and goes straight to the finish state.
// a held output stalls the readback only when a second data byte is due.
// reset clears control state at once; the block store needs no clearing.
`default_nettype none

module hamming_secded_block_decoder_top
  import hsd_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_LOG2 = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  hsd_in_if.sink                coded_i,
  hsd_out_if.source             result_o
);

  localparam int unsigned AW    = (MAX_BLOCK_LOG2 > MIN_LOG2) ? MAX_BLOCK_LOG2 - MIN_LOG2 : 1;
  localparam int unsigned KW    = AW + 1;
  localparam int unsigned PW    = AW + 3;
  localparam int unsigned DEPTH = 1 << AW;

  state_e state_q, state_d;

  logic [CFG_W-1:0]    cfg_q;
  logic [CFG_W-1:0]    eff_log2;
  logic [KW-1:0]       nbytes;

  logic [AW-1:0]       idx_q;
  logic [PW-1:0]       syn_q, syn_n, flip_q;
  logic                par_q, par_n, bit0_q, bit0_n;
  logic [STATUS_W-1:0] status_q;

  logic [BYTE_W-1:0]   mem [DEPTH];
  logic [BYTE_W-1:0]   rdata_q, rdata_fix;
  logic [AW-1:0]       rk_q;
  logic                rvalid_q;
  logic [KW-1:0]       k_q;

  logic                pend_valid_q;
  logic [BYTE_W-1:0]   pend_byte_q;

  logic                out_valid_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic                out_bvalid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_last_q;

  logic [BYTE_W-1:0]   byte_m;
  logic                odd;
  logic [2:0]          jx;
  logic                is_end;
  logic                in_fire, in_ready;
  logic                out_free, rd_done, issue, proc_fire, push_mid, fin_fire;
  pack_ctrl_t          pk_ctrl;
  pack_stat_t          pk_stat;

  // clamp the block length register to the supported range
  always_comb begin
    priority if (cfg_q < CFG_W'(MIN_LOG2)) begin
      eff_log2 = CFG_W'(MIN_LOG2);
    end else if (cfg_q > CFG_W'(MAX_BLOCK_LOG2)) begin
      eff_log2 = CFG_W'(MAX_BLOCK_LOG2);
    end else begin
      eff_log2 = cfg_q;
    end
  end

  assign nbytes = KW'(1) << (eff_log2 - CFG_W'(MIN_LOG2));

  // per byte: position bit 0 is not covered; high index bits enter on odd weight
  assign byte_m = (idx_q == '0) ? {coded_i.coded_byte[7:1], 1'b0} : coded_i.coded_byte;
  assign odd    = ^byte_m;
  assign jx[0]  = byte_m[1] ^ byte_m[3] ^ byte_m[5] ^ byte_m[7];
  assign jx[1]  = byte_m[2] ^ byte_m[3] ^ byte_m[6] ^ byte_m[7];
  assign jx[2]  = byte_m[4] ^ byte_m[5] ^ byte_m[6] ^ byte_m[7];
  assign syn_n  = syn_q ^ (odd ? {idx_q, 3'b000} : '0) ^ {{AW{1'b0}}, jx};
  assign par_n  = par_q ^ odd;
  assign bit0_n = (idx_q == '0) ? coded_i.coded_byte[0] : bit0_q;
  assign is_end = ({1'b0, idx_q} + KW'(1)) == nbytes;

  assign out_free  = !out_valid_q || result_o.ready;
  assign rd_done   = (k_q == nbytes);
  assign proc_fire = rvalid_q && (!pk_stat.full || !pend_valid_q || out_free);
  assign issue     = (state_q == ST_EXTRACT) && !rd_done && (!rvalid_q || proc_fire);
  assign push_mid  = proc_fire && pk_stat.full && pend_valid_q;
  assign fin_fire  = (state_q == ST_FINISH) && out_free;
  assign in_fire   = coded_i.valid && in_ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_fire && is_end) begin
          if ((syn_n != '0) && (par_n == bit0_n)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_EXTRACT;
          end
        end
      end
      ST_EXTRACT: begin
        if (rd_done && !rvalid_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_fire) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    unique case (state_q)
      ST_COLLECT: in_ready = 1'b1;
      ST_EXTRACT: in_ready = 1'b0;
      ST_FINISH:  in_ready = 1'b0;
      default:    in_ready = 1'b0;
    endcase
  end

  assign coded_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // block accumulation and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CFG_W'(MIN_LOG2);
      idx_q    <= '0;
      syn_q    <= '0;
      par_q    <= 1'b0;
      bit0_q   <= 1'b0;
      status_q <= STATUS_CLEAN;
      flip_q   <= '0;
    end else begin
      if (in_fire) begin
        bit0_q <= bit0_n;
        if (is_end) begin
          idx_q  <= '0;
          syn_q  <= '0;
          par_q  <= 1'b0;
          flip_q <= syn_n;
          if (syn_n == '0) begin
            status_q <= STATUS_CLEAN;
          end else if (par_n != bit0_n) begin
            status_q <= STATUS_CORRECTED;
          end else begin
            status_q <= STATUS_DROPPED;
          end
        end else begin
          idx_q <= idx_q + AW'(1);
          syn_q <= syn_n;
          par_q <= par_n;
        end
      end
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
        idx_q <= '0;
        syn_q <= '0;
        par_q <= 1'b0;
      end
    end
  end

  // block store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem[idx_q] <= coded_i.coded_byte;
    end
    if (issue) begin
      rdata_q <= mem[k_q[AW-1:0]];
      rk_q    <= k_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      k_q      <= '0;
    end else begin
      if (in_fire && is_end) begin
        k_q <= '0;
      end else if (issue) begin
        k_q <= k_q + KW'(1);
      end
      if (issue) begin
        rvalid_q <= 1'b1;
      end else if (proc_fire) begin
        rvalid_q <= 1'b0;
      end
    end
  end

  // single error correction is applied on the way out of the store
  always_comb begin
    rdata_fix = rdata_q;
    if ((status_q == STATUS_CORRECTED) && (flip_q[PW-1:3] == rk_q)) begin
      rdata_fix[flip_q[2:0]] = ~rdata_q[flip_q[2:0]];
    end
  end

  assign pk_ctrl.clear = cfg_we_i;
  assign pk_ctrl.step  = proc_fire;
  assign pk_ctrl.first = (rk_q == '0);
  assign pk_ctrl.pow2  = $onehot(rk_q);

  hsd_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (pk_ctrl),
    .byte_i (rdata_fix),
    .stat_o (pk_stat)
  );

  // one finished byte is held back until it is known whether it is the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      if (proc_fire && pk_stat.full) begin
        pend_valid_q <= 1'b1;
      end else if (fin_fire) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && pk_stat.full) begin
      pend_byte_q <= pk_stat.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (push_mid || fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_mid) begin
      out_byte_q   <= pend_byte_q;
      out_bvalid_q <= 1'b1;
      out_status_q <= status_q;
      out_last_q   <= 1'b0;
    end else if (fin_fire) begin
      out_byte_q   <= pend_valid_q ? pend_byte_q : '0;
      out_bvalid_q <= pend_valid_q;
      out_status_q <= status_q;
      out_last_q   <= 1'b1;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.data_byte  = out_byte_q;
  assign result_o.byte_valid = out_bvalid_q;
  assign result_o.status     = out_status_q;
  assign result_o.last       = out_last_q;

  a_read_in_extract: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == ST_EXTRACT))
    else $error("store read data outside readback");

  a_pend_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_EXTRACT) || (state_q == ST_FINISH))
    else $error("held byte outside block end");

  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXTRACT) |-> (k_q <= nbytes))
    else $error("readback past block end");

  a_drop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STATUS_DROPPED)) |-> (!out_bvalid_q && out_last_q))
    else $error("dropped block result carries data");

  a_no_drop_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXTRACT) |-> (status_q != STATUS_DROPPED))
    else $error("readback of a dropped block");

endmodule

`default_nettype wire

// ===== bench/hamming_secded_block_decoder_top_test.sv =====
// hamming_secded_block_decoder_top_test: random and directed test of the secded block decoder
module hamming_secded_block_decoder_top_test;
  import hsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic                byte_valid;
    logic [STATUS_W-1:0] status;
    logic                last;
  } decoded_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  hsd_in_if  coded_if ();
  hsd_out_if result_if ();

  hamming_secded_block_decoder_top #(
    .MAX_BLOCK_LOG2(9)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coded_i    (coded_if),
    .result_o   (result_if)
  );

  logic [BYTE_W-1:0] pending_bytes[$];
  decoded_t          decoded_due[$];

  // decoder state as the block should hold it
  logic [7:0]       blk_store[64];
  int unsigned      blk_fill;
  logic [8:0]       run_syn;
  logic             run_par;
  logic [7:0]       pend_bits;
  int unsigned      pend_cnt;
  logic [CFG_W-1:0] blk_log2;

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned results_checked;
  int unsigned status_seen[4];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               decoded_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned span_log2(input logic [CFG_W-1:0] v);
    if (v < MIN_LOG2) return MIN_LOG2;
    if (v > 9) return 9;
    return 32'(v);
  endfunction

  function automatic void decode_coded_byte(input logic [7:0] cb);
    int unsigned lg, nbytes, nbits, idx, pos, nxt, s;
    logic [8:0]          syn;
    logic                par;
    logic [STATUS_W-1:0] st;
    decoded_t            held;
    bit                  have_held;
    lg = span_log2(blk_log2);
    nbytes = 1 << (lg - 3);
    nbits = 1 << lg;
    idx = blk_fill;
    blk_store[idx] = cb;
    for (int j = 0; j < 8; j++) begin
      pos = idx * 8 + j;
      if (cb[j] && pos != 0) begin
        run_syn ^= pos[8:0];
        run_par ^= 1'b1;
      end
    end
    if (idx + 1 < nbytes) begin
      blk_fill = idx + 1;
      return;
    end
    syn = run_syn;
    par = run_par;
    blk_fill = 0;
    run_syn = '0;
    run_par = 1'b0;
    st = STATUS_CLEAN;
    if (syn != 0) begin
      // parity agrees with a nonzero syndrome: two errors, block is dropped
      if (par == blk_store[0][0]) begin
        decoded_due.push_back(decoded_t'{8'h00, 1'b0, STATUS_DROPPED, 1'b1});
        return;
      end
      s = syn & (nbits - 1);
      blk_store[s >> 3][s & 7] = ~blk_store[s >> 3][s & 7];
      st = STATUS_CORRECTED;
    end
    have_held = 1'b0;
    held = '0;
    nxt = 4;
    for (int i = 3; i < nbits; i++) begin
      if (i == nxt) begin
        nxt <<= 1;
      end else begin
        pend_bits[pend_cnt] = blk_store[i >> 3][i & 7];
        pend_cnt++;
        if (pend_cnt == 8) begin
          // hold back one byte so the final one can carry last
          if (have_held) decoded_due.push_back(held);
          held = decoded_t'{pend_bits, 1'b1, st, 1'b0};
          have_held = 1'b1;
          pend_bits = '0;
          pend_cnt = 0;
        end
      end
    end
    if (!have_held) held = decoded_t'{8'h00, 1'b0, st, 1'b0};
    held.last = 1'b1;
    decoded_due.push_back(held);
  endfunction

  function automatic void report_failure(input string what, input decoded_t want,
                                         input decoded_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s: expected data %02h byte_valid %0b status %0d last %0b",
               what, want.data_byte, want.byte_valid, want.status, want.last);
      $display("%s: got      data %02h byte_valid %0b status %0d last %0b",
               what, got.data_byte, got.byte_valid, got.status, got.last);
    end
  endfunction

  // coded byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coded_if.valid <= 1'b0;
      coded_if.coded_byte <= '0;
    end else begin
      if (coded_if.valid && coded_if.ready) begin
        decode_coded_byte(coded_if.coded_byte);
        bytes_sent++;
      end
      if (!coded_if.valid || coded_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          coded_if.valid <= 1'b1;
          coded_if.coded_byte <= pending_bytes.pop_front();
        end else begin
          coded_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin : take_result
      decoded_t got;
      decoded_t want;
      if (result_if.valid && result_if.ready) begin
        got = decoded_t'{result_if.data_byte, result_if.byte_valid, result_if.status,
                         result_if.last};
        status_seen[got.status]++;
        results_checked++;
        if (decoded_due.size() == 0) begin
          report_failure("result with nothing due", '0, got);
        end else begin
          want = decoded_due.pop_front();
          if (got !== want) report_failure("result mismatch", want, got);
        end
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // wait until every item is in and every result is out, then let the block settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || coded_if.valid || decoded_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_block_log2(input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blk_log2 = v;
    blk_fill = 0;
    run_syn = '0;
    run_par = 1'b0;
    pend_bits = '0;
    pend_cnt = 0;
    @(negedge clk_i);
  endtask

  // encoded blocks with none, one or two flipped bits, some pure noise;
  // an optional partial block at the end is cleared by the next write
  task automatic queue_blocks(input int unsigned count, input bit tail);
    logic [511:0] bits;
    int unsigned  lg, nbits, syn, par, a, b, mix;
    lg = span_log2(blk_log2);
    nbits = 1 << lg;
    repeat (count) begin
      bits = '0;
      syn = 0;
      par = 0;
      for (int i = 3; i < nbits; i++)
        if ((i & (i - 1)) != 0) bits[i] = 1'($urandom_range(1));
      for (int i = 1; i < nbits; i++)
        if (bits[i]) syn ^= i;
      for (int k = 0; k < lg; k++) bits[1 << k] = syn[k];
      for (int i = 1; i < nbits; i++) par ^= 32'(bits[i]);
      bits[0] = par[0];
      mix = $urandom_range(99);
      a = $urandom_range(nbits - 1);
      do b = $urandom_range(nbits - 1); while (b == a);
      if (mix >= 90) begin
        for (int k = 0; k < 16; k++) bits[32 * k +: 32] = $urandom();
      end else if (mix >= 72) begin
        bits[a] = ~bits[a];
        bits[b] = ~bits[b];
      end else if (mix >= 65) begin
        bits[0] = ~bits[0];
      end else if (mix >= 35) begin
        bits[a] = ~bits[a];
      end
      for (int k = 0; k < nbits / 8; k++) pending_bytes.push_back(bits[8 * k +: 8]);
    end
    if (tail) repeat ($urandom_range(nbits / 8 - 1)) pending_bytes.push_back(8'($urandom()));
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] v, input int unsigned count,
                           input bit tail);
    write_block_log2(v);
    queue_blocks(count, tail);
    drain();
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    blk_log2 = 4'd3;
    blk_fill = 0;
    run_syn = '0;
    run_par = 1'b0;
    pend_bits = '0;
    pend_cnt = 0;
    foreach (blk_store[i]) blk_store[i] = '0;
    send_idle = 14;
    recv_idle = 59;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one-byte blocks at the reset size: clean, bit 0 only, single and double
    // errors, status-only results on odd blocks, drop with carried bits kept
    pending_bytes = '{8'h00, 8'hFF, 8'h01, 8'h08, 8'h06, 8'h80, 8'h7F, 8'hFE,
                      8'h96, 8'h69, 8'hAA, 8'h55, 8'h3C, 8'hC3, 8'h06, 8'hE8,
                      8'h17, 8'hF0, 8'h0F, 8'h01};
    drain();

    run_phase(4'd0, 20, 1'b0);
    run_phase(4'd4, 20, 1'b1);
    run_phase(4'd15, 1, 1'b1);
    send_idle = 59;
    recv_idle = 14;
    run_phase(4'd5, 10, 1'b1);
    run_phase(4'd2, 20, 1'b0);
    run_phase(4'd9, 1, 1'b0);
    send_idle = 0;
    recv_idle = 0;
    run_phase(4'd6, 5, 1'b1);
    run_phase(4'd7, 2, 1'b1);
    run_phase(4'd8, 1, 1'b0);

    $display("summary: %0d coded bytes over block sizes 8 to 512 bits, %0d results checked",
             bytes_sent, results_checked);
    $display("summary: %0d clean, %0d corrected, %0d dropped, %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], fail_count);
    if (fail_count == 0 && decoded_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
